>>> rtl/core/sst_pkg.sv
// Types, codes and character helpers shared by the source tokenizer.
package sst_pkg;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  token_class;
        logic [4:0]  keyword_id;
        logic [15:0] start_line;
        logic [15:0] start_column;
        logic [15:0] token_length;
        logic        last_of_run;
    } t_out_item;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_NUM_FIRST, M_NUM_INT, M_NUM_HEX, M_NUM_FRAC,
        M_STRING, M_LINE_COMMENT, M_BLOCK_COMMENT, M_SYMBOL
    } t_mode;

    localparam logic [5:0] K_IDENT = 6'd0, K_KEYWORD = 6'd1, K_NUMBER = 6'd2,
        K_STRING = 6'd3, K_COMMENT = 6'd4, K_INVALID = 6'd5, K_DOT = 6'd6,
        K_COMMA = 6'd7, K_QUESTION = 6'd8, K_COLON = 6'd9, K_SEMI = 6'd10,
        K_LBRACE = 6'd11, K_RBRACE = 6'd12, K_LPAREN = 6'd13, K_RPAREN = 6'd14,
        K_LBRACKET = 6'd15, K_RBRACKET = 6'd16, K_PIPE = 6'd17, K_ADD = 6'd18,
        K_SUB = 6'd19, K_MUL = 6'd20, K_DIV = 6'd21, K_MOD = 6'd22,
        K_EXP = 6'd23, K_CONCAT = 6'd24, K_LT = 6'd25, K_LTE = 6'd26,
        K_GT = 6'd27, K_GTE = 6'd28, K_EQ = 6'd29, K_NEQ = 6'd30,
        K_AND = 6'd31, K_OR = 6'd32, K_NOT = 6'd33, K_ASSIGN = 6'd34,
        K_ASSIGN_ADD = 6'd35, K_ASSIGN_SUB = 6'd36, K_ASSIGN_MUL = 6'd37,
        K_ASSIGN_DIV = 6'd38, K_ASSIGN_CONCAT = 6'd39, K_INC = 6'd40,
        K_DEC = 6'd41;
    localparam logic [5:0] K_NONE = 6'd63;
    localparam logic [4:0] NOT_KEYWORD = 5'd16;

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    endfunction

    function automatic logic is_dec(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        return is_dec(b) || (b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46);
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b == 8'h20 || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        case (c)
            "+":     return K_ADD;
            "-":     return K_SUB;
            "*":     return K_MUL;
            "/":     return K_DIV;
            "@":     return K_CONCAT;
            "<":     return K_LT;
            ">":     return K_GT;
            "!":     return K_NOT;
            "=":     return K_ASSIGN;
            "|":     return K_PIPE;
            ".":     return K_DOT;
            default: return K_INVALID;
        endcase
    endfunction

    function automatic logic [5:0] pair_kind(input logic [7:0] c, input logic [7:0] b);
        logic [5:0] k;
        k = K_NONE;
        if (b == "=") begin
            case (c)
                "+":     k = K_ASSIGN_ADD;
                "-":     k = K_ASSIGN_SUB;
                "*":     k = K_ASSIGN_MUL;
                "/":     k = K_ASSIGN_DIV;
                "@":     k = K_ASSIGN_CONCAT;
                "<":     k = K_LTE;
                ">":     k = K_GTE;
                "!":     k = K_NEQ;
                "=":     k = K_EQ;
                default: k = K_NONE;
            endcase
        end else if (c == "+" && b == "+") begin
            k = K_INC;
        end else if (c == "-" && b == "-") begin
            k = K_DEC;
        end else if (c == "|" && b == "|") begin
            k = K_OR;
        end else if (c == "&" && b == "&") begin
            k = K_AND;
        end
        return k;
    endfunction

    function automatic logic [5:0] start_kind(input logic [7:0] b);
        case (b)
            ",":     return K_COMMA;
            "?":     return K_QUESTION;
            ":":     return K_COLON;
            ";":     return K_SEMI;
            "{":     return K_LBRACE;
            "}":     return K_RBRACE;
            "(":     return K_LPAREN;
            ")":     return K_RPAREN;
            "[":     return K_LBRACKET;
            "]":     return K_RBRACKET;
            "%":     return K_MOD;
            "^":     return K_EXP;
            default: return K_INVALID;
        endcase
    endfunction

endpackage

>>> rtl/core/sst_keyword.sv
// Keyword matcher over the held identifier prefix.
module sst_keyword #(
    parameter int KEYWORD_BYTES = 8,
    parameter int POSITION_BITS = 16
) (
    input  logic [KEYWORD_BYTES*8-1:0] i_prefix,
    input  logic [POSITION_BITS-1:0]   i_count,
    output logic [5:0]                 o_kind,
    output logic [4:0]                 o_kw
);
    import sst_pkg::*;

    logic [63:0] w;
    logic [7:0]  c8;

    assign w = i_prefix[63:0];
    assign c8 = (i_count > POSITION_BITS'(8)) ? 8'd255 : 8'(i_count);

    always_comb begin
        o_kind = K_KEYWORD;
        o_kw   = NOT_KEYWORD;
        if (c8 == 8'd3 && w[23:0] == {"C", "P", "S"}) begin
            o_kind = K_CONCAT;
        end else if (c8 == 8'd2 && w[15:0] == {"f", "i"}) begin
            o_kw = 5'd0;
        end else if (c8 == 8'd4 && w[31:0] == {"e", "s", "l", "e"}) begin
            o_kw = 5'd1;
        end else if (c8 == 8'd5 && w[39:0] == {"e", "l", "i", "h", "w"}) begin
            o_kw = 5'd2;
        end else if (c8 == 8'd3 && w[23:0] == {"r", "o", "f"}) begin
            o_kw = 5'd3;
        end else if (c8 == 8'd8 && w == {"n", "o", "i", "t", "c", "n", "u", "f"}) begin
            o_kw = 5'd4;
        end else if (c8 == 8'd6 && w[47:0] == {"n", "r", "u", "t", "e", "r"}) begin
            o_kw = 5'd5;
        end else if (c8 == 8'd3 && w[23:0] == {"w", "e", "n"}) begin
            o_kw = 5'd6;
        end else if (c8 == 8'd4 && w[31:0] == {"h", "t", "i", "w"}) begin
            o_kw = 5'd7;
        end else if (c8 == 8'd2 && w[15:0] == {"n", "i"}) begin
            o_kw = 5'd8;
        end else if (c8 == 8'd5 && w[39:0] == {"k", "a", "e", "r", "b"}) begin
            o_kw = 5'd9;
        end else if (c8 == 8'd8 && w == {"e", "u", "n", "i", "t", "n", "o", "c"}) begin
            o_kw = 5'd10;
        end else if (c8 == 8'd4 && (w[31:0] == {"l", "l", "u", "n"}
                                 || w[31:0] == {"L", "L", "U", "N"})) begin
            o_kw = 5'd11;
        end else if (c8 == 8'd4 && w[31:0] == {"e", "u", "r", "t"}) begin
            o_kw = 5'd12;
        end else if (c8 == 8'd5 && w[39:0] == {"e", "s", "l", "a", "f"}) begin
            o_kw = 5'd13;
        end else if (c8 == 8'd6 && w[47:0] == {"h", "c", "t", "i", "w", "s"}) begin
            o_kw = 5'd14;
        end else if (c8 == 8'd4 && w[31:0] == {"e", "s", "a", "c"}) begin
            o_kw = 5'd15;
        end else begin
            o_kind = K_IDENT;
        end
    end
endmodule

>>> rtl/core/sst_obuf.sv
// Four-entry result queue between the scanner and the output channel.
module sst_obuf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push0,
    input  logic               i_push1,
    input  sst_pkg::t_out_item i_item0,
    input  sst_pkg::t_out_item i_item1,
    output logic               o_room,
    output logic               o_valid,
    output sst_pkg::t_out_item o_item,
    input  logic               i_stall
);
    import sst_pkg::*;

    t_out_item   r_q [4];
    logic [1:0]  r_rd, r_wr;
    logic [2:0]  r_cnt;
    logic        pop;
    logic [2:0]  pushes;

    assign o_valid = r_cnt != 3'd0;
    assign o_item  = r_q[r_rd];
    assign pop     = o_valid && !i_stall;
    assign o_room  = r_cnt <= 3'd2;
    assign pushes  = {2'b0, i_push0} + {2'b0, i_push1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push0) r_q[r_wr] <= i_item0;
            if (i_push1) r_q[r_wr + {1'b0, i_push0}] <= i_item1;
            r_wr  <= r_wr + pushes[1:0];
            r_rd  <= r_rd + {1'b0, pop};
            r_cnt <= r_cnt + pushes - {2'b0, pop};
        end
    end
endmodule

>>> rtl/core/script_source_tokenizer_top.sv
// Top level of the streaming source tokenizer.
// Usage: feed one source byte per item on the input channel (valid/stall);
// set end_of_input to flush a pending token and restart line and column at 1.
// Each item yields zero, one or two tokens on the output channel; the last
// token caused by an item carries last_of_run.
// A token is written into the output queue when the byte that closes it
// is accepted. Throughput: one byte per cycle while the output queue has
// room for two tokens; the scanner state updates in that cycle.
// The output side is a four-entry queue, so input is taken while earlier
// tokens wait; input stalls only when fewer than two slots remain.
// A bad escape, a lone '&' or an unknown byte emits an invalid token and
// halts the block: later bytes are taken and dropped until reset.
// Reset: synchronous, active low; clears the queue and scanner state,
// line and column restart at 1.
module script_source_tokenizer_top #(
    parameter int KEYWORD_BYTES = 8,
    parameter int POSITION_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  sst_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output sst_pkg::t_out_item o_item
);
    import sst_pkg::*;

    localparam int PB = POSITION_BITS;
    localparam logic [PB-1:0] PMAX = {PB{1'b1}};
    localparam logic [PB-1:0] ONE  = PB'(1);

    t_mode                    r_mode, n_mode;
    logic [7:0]               r_sym, n_sym;
    logic [KEYWORD_BYTES*8-1:0] r_pre, n_pre;
    logic                     r_esc, n_esc, r_star, n_star, r_halt, n_halt;
    logic [PB-1:0]            r_tl, n_tl, r_tc, n_tc, r_cnt, n_cnt, r_line, n_line;
    logic [PB-1:0]            r_col, n_col;

    logic       acc, room;
    logic [7:0] b;
    logic [PB-1:0] nl, nc;
    logic [5:0] kw_kind;
    logic [4:0] kw_id;
    logic       e0, e1;
    t_out_item  t0, t1;

    assign acc     = i_valid && !o_stall;
    assign o_stall = !room;
    assign b       = i_item.source_byte;

    sst_keyword #(.KEYWORD_BYTES(KEYWORD_BYTES), .POSITION_BITS(POSITION_BITS)) u_kw (
        .i_prefix(r_pre), .i_count(r_cnt), .o_kind(kw_kind), .o_kw(kw_id));

    function automatic logic [PB-1:0] sat(input logic [PB-1:0] v);
        return (v == PMAX) ? v : v + ONE;
    endfunction

    function automatic t_out_item mk(input logic [5:0] k, input logic [4:0] w,
                                     input logic [PB-1:0] l, input logic [PB-1:0] c,
                                     input logic [PB-1:0] n);
        t_out_item t;
        t.token_class  = k;
        t.keyword_id   = w;
        t.start_line   = 16'(l);
        t.start_column = 16'(c);
        t.token_length = 16'(n);
        t.last_of_run  = 1'b0;
        return t;
    endfunction

    always_comb begin
        logic took;
        logic [5:0] pk, sk;
        n_mode = r_mode; n_sym = r_sym; n_pre = r_pre; n_esc = r_esc;
        n_star = r_star; n_halt = r_halt; n_tl = r_tl; n_tc = r_tc;
        n_cnt = r_cnt; n_line = r_line; n_col = r_col;
        e0 = 1'b0; e1 = 1'b0;
        t0 = mk(K_IDENT, NOT_KEYWORD, r_tl, r_tc, r_cnt);
        t1 = t0;
        took = 1'b0;
        pk = pair_kind(r_sym, b);
        sk = single_kind(r_sym);
        if (b == 8'h0A) begin
            nl = sat(r_line); nc = ONE;
        end else begin
            nl = r_line; nc = sat(r_col);
        end
        if (acc && !r_halt) begin
            if (i_item.end_of_input) begin
                case (r_mode)
                    M_IDENT: begin
                        e0 = 1'b1; t0 = mk(kw_kind, kw_id, r_tl, r_tc, r_cnt);
                    end
                    M_NUM_FIRST, M_NUM_INT, M_NUM_HEX, M_NUM_FRAC: begin
                        e0 = 1'b1; t0 = mk(K_NUMBER, NOT_KEYWORD, r_tl, r_tc, r_cnt);
                    end
                    M_STRING: begin
                        e0 = 1'b1;
                        if (r_esc) begin
                            t0 = mk(K_INVALID, NOT_KEYWORD, r_line, r_col, r_cnt);
                            n_halt = 1'b1;
                        end else begin
                            t0 = mk(K_STRING, NOT_KEYWORD, r_tl, r_tc, r_cnt);
                        end
                    end
                    M_LINE_COMMENT, M_BLOCK_COMMENT: begin
                        e0 = 1'b1; t0 = mk(K_COMMENT, NOT_KEYWORD, r_tl, r_tc, r_cnt);
                    end
                    M_SYMBOL: begin
                        e0 = 1'b1; t0 = mk(sk, NOT_KEYWORD, r_tl, r_tc, r_cnt);
                        if (sk == K_INVALID) n_halt = 1'b1;
                    end
                    default: ;
                endcase
                n_mode = M_IDLE; n_esc = 1'b0; n_star = 1'b0;
                n_line = ONE; n_col = ONE;
            end else begin
                case (r_mode)
                    M_IDENT: begin
                        if (b == "_" || is_letter(b) || is_dec(b)) begin
                            took = 1'b1;
                            for (int i = 0; i < KEYWORD_BYTES; i++) begin
                                if (r_cnt == PB'(i)) n_pre[i*8 +: 8] = b;
                            end
                            n_cnt = sat(r_cnt);
                        end else begin
                            e0 = 1'b1; t0 = mk(kw_kind, kw_id, r_tl, r_tc, r_cnt);
                        end
                    end
                    M_NUM_FIRST, M_NUM_INT: begin
                        took = 1'b1; n_cnt = sat(r_cnt);
                        if (r_mode == M_NUM_FIRST && b == "x") n_mode = M_NUM_HEX;
                        else if (is_dec(b)) n_mode = M_NUM_INT;
                        else if (b == ".") n_mode = M_NUM_FRAC;
                        else begin
                            took = 1'b0; n_cnt = r_cnt;
                            e0 = 1'b1; t0 = mk(K_NUMBER, NOT_KEYWORD, r_tl, r_tc, r_cnt);
                        end
                    end
                    M_NUM_HEX, M_NUM_FRAC: begin
                        if (r_mode == M_NUM_HEX ? is_hex(b) : is_dec(b)) begin
                            took = 1'b1; n_cnt = sat(r_cnt);
                        end else begin
                            e0 = 1'b1; t0 = mk(K_NUMBER, NOT_KEYWORD, r_tl, r_tc, r_cnt);
                        end
                    end
                    M_STRING: begin
                        took = 1'b1; n_cnt = sat(r_cnt);
                        if (r_esc) begin
                            if (b == "n" || b == "r" || b == "\"" || b == "\\") begin
                                n_esc = 1'b0;
                            end else begin
                                e0 = 1'b1;
                                t0 = mk(K_INVALID, NOT_KEYWORD, nl, nc, sat(r_cnt));
                                n_mode = M_IDLE; n_halt = 1'b1;
                            end
                        end else if (b == "\\") begin
                            n_esc = 1'b1;
                        end else if (b == "\"") begin
                            e0 = 1'b1;
                            t0 = mk(K_STRING, NOT_KEYWORD, r_tl, r_tc, sat(r_cnt));
                            n_mode = M_IDLE;
                        end
                    end
                    M_LINE_COMMENT: begin
                        if (b == 8'h0A) begin
                            e0 = 1'b1; t0 = mk(K_COMMENT, NOT_KEYWORD, r_tl, r_tc, r_cnt);
                        end else begin
                            took = 1'b1; n_cnt = sat(r_cnt);
                        end
                    end
                    M_BLOCK_COMMENT: begin
                        took = 1'b1; n_cnt = sat(r_cnt);
                        if (r_star && b == "/") begin
                            e0 = 1'b1;
                            t0 = mk(K_COMMENT, NOT_KEYWORD, r_tl, r_tc, sat(r_cnt));
                            n_mode = M_IDLE;
                        end else begin
                            n_star = (b == "*");
                        end
                    end
                    M_SYMBOL: begin
                        if (r_sym == "/" && (b == "/" || b == "*")) begin
                            took = 1'b1; n_cnt = sat(r_cnt); n_star = 1'b0;
                            n_mode = (b == "/") ? M_LINE_COMMENT : M_BLOCK_COMMENT;
                        end else if (r_sym == "." && is_dec(b)) begin
                            took = 1'b1; n_cnt = sat(r_cnt); n_mode = M_NUM_FRAC;
                        end else if (pk != K_NONE) begin
                            took = 1'b1; n_cnt = sat(r_cnt);
                            e0 = 1'b1;
                            t0 = mk(pk, NOT_KEYWORD, r_tl, r_tc, sat(r_cnt));
                            n_mode = M_IDLE;
                        end else begin
                            e0 = 1'b1; t0 = mk(sk, NOT_KEYWORD, r_tl, r_tc, r_cnt);
                            n_mode = M_IDLE;
                            if (sk == K_INVALID) begin
                                n_halt = 1'b1; took = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
                if (!took) begin
                    n_tl = r_line; n_tc = r_col; n_cnt = ONE; n_mode = M_IDLE;
                    if (is_space(b)) begin
                    end else if (b == "_" || is_letter(b)) begin
                        n_pre[7:0] = b; n_mode = M_IDENT;
                    end else if (is_dec(b)) begin
                        n_mode = M_NUM_FIRST;
                    end else if (b == "\"") begin
                        n_mode = M_STRING; n_esc = 1'b0;
                    end else if (b inside {"+", "-", "*", "/", "@", "<", ">", "!", "=",
                                           "|", "&", "."}) begin
                        n_sym = b; n_mode = M_SYMBOL;
                    end else begin
                        e1 = 1'b1;
                        t1 = mk(start_kind(b), NOT_KEYWORD, r_line, r_col, ONE);
                        if (start_kind(b) == K_INVALID) n_halt = 1'b1;
                    end
                end
                n_line = nl; n_col = nc;
            end
        end
        if (e1 && !e0) begin
            e0 = 1'b1; t0 = t1; e1 = 1'b0;
        end
        if (e1) t1.last_of_run = 1'b1;
        else if (e0) t0.last_of_run = 1'b1;
    end

    sst_obuf u_obuf (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push0(e0), .i_push1(e1),
        .i_item0(t0), .i_item1(t1), .o_room(room), .o_valid(o_valid),
        .o_item(o_item), .i_stall(i_stall));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_sym <= '0; r_pre <= '0; r_esc <= 1'b0;
            r_star <= 1'b0; r_halt <= 1'b0; r_tl <= ONE; r_tc <= ONE;
            r_cnt <= '0; r_line <= ONE; r_col <= ONE;
        end else begin
            r_mode <= n_mode; r_sym <= n_sym; r_pre <= n_pre; r_esc <= n_esc;
            r_star <= n_star; r_halt <= n_halt; r_tl <= n_tl; r_tc <= n_tc;
            r_cnt <= n_cnt; r_line <= n_line; r_col <= n_col;
        end
    end

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt) else $error("halt cleared without reset");
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |-> !e0 && !e1) else $error("token emitted while halted");
    a_line_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line != '0 && r_col != '0) else $error("position fell to zero");
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        e1 |-> e0 && !t0.last_of_run) else $error("second token without first");
endmodule

>>> bench/tb_script_source_tokenizer_top.sv
// Self-checking bench for the source tokenizer: directed table, random token streams, halt.
module tb_script_source_tokenizer_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sst_pkg::*;

    localparam int          CYCLE_LIMIT = 3000000;
    localparam logic [7:0]  CH_NL = 8'h0A, CH_QUOTE = 8'h22, CH_BSL = 8'h5C;
    localparam logic [4:0]  NK = NOT_KEYWORD;

    typedef struct {
        t_in_item  it;
        bit        chk;
        t_out_item v;
    } t_src_entry;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_item  i_item = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_item o_item;

    script_source_tokenizer_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_item(i_item), .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    t_src_entry src_q[$];
    t_src_entry cur_row;
    t_out_item  token_q[$];
    t_out_item  step_res[$];
    int         errors = 0;
    int         snd_idle = 11;
    int         rcv_idle = 81;
    bit         hold_go = 0;
    int         hold_left = 0;
    int         cyc = 0;

    string      kw_txt[17] = '{"if", "else", "while", "for", "function", "return", "new",
                               "with", "in", "break", "continue", "null", "NULL", "true",
                               "false", "switch", "case"};
    logic [4:0] kw_id[17] = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9,
                              5'd10, 5'd11, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15};

    // tokenizer state
    t_mode       md = M_IDLE;
    logic [7:0]  psym = '0;
    logic [7:0]  kwp[8] = '{default: 8'h00};
    bit          esc = 0, star = 0, halt = 0;
    logic [15:0] tsl = 16'd1, tsc = 16'd1, tcnt = 16'd0, cl = 16'd1, cc = 16'd1;

    function automatic logic [15:0] sat16(logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction
    function automatic bit ch_alpha(logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction
    function automatic bit ch_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction
    function automatic bit ch_hexd(logic [7:0] b);
        return ch_digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    endfunction
    function automatic bit ch_blank(logic [7:0] b);
        return b == " " || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic [5:0] lone_kind(logic [7:0] c);
        case (c)
            "+": return K_ADD;
            "-": return K_SUB;
            "*": return K_MUL;
            "/": return K_DIV;
            "@": return K_CONCAT;
            "<": return K_LT;
            ">": return K_GT;
            "!": return K_NOT;
            "=": return K_ASSIGN;
            "|": return K_PIPE;
            ".": return K_DOT;
            default: return K_INVALID;
        endcase
    endfunction

    function automatic logic [5:0] duo_kind(logic [7:0] c, logic [7:0] b);
        if (b == "=") begin
            case (c)
                "+": return K_ASSIGN_ADD;
                "-": return K_ASSIGN_SUB;
                "*": return K_ASSIGN_MUL;
                "/": return K_ASSIGN_DIV;
                "@": return K_ASSIGN_CONCAT;
                "<": return K_LTE;
                ">": return K_GTE;
                "!": return K_NEQ;
                "=": return K_EQ;
                default: return K_NONE;
            endcase
        end
        if (c == "+" && b == "+") return K_INC;
        if (c == "-" && b == "-") return K_DEC;
        if (c == "|" && b == "|") return K_OR;
        if (c == "&" && b == "&") return K_AND;
        return K_NONE;
    endfunction

    task automatic emit(logic [5:0] k, logic [4:0] kw, logic [15:0] ln, logic [15:0] co,
                        logic [15:0] len);
        t_out_item t;
        t = '{k, kw, ln, co, len, 1'b0};
        if (step_res.size() < 2) step_res.insert(step_res.size(), t);
    endtask

    task automatic emit_tok(logic [5:0] k, logic [4:0] kw);
        emit(k, kw, tsl, tsc, tcnt);
        md = M_IDLE;
    endtask

    task automatic close_word();
        logic [5:0] k;
        logic [4:0] kw;
        bit         hit, found;
        int         i, j;
        k = K_IDENT;
        kw = NK;
        found = 0;
        if (tcnt == 3 && kwp[0] == "S" && kwp[1] == "P" && kwp[2] == "C") begin
            k = K_CONCAT;
        end else if (tcnt <= 8) begin
            for (i = 0; i < 17; i++) begin
                if (!found && kw_txt[i].len() == tcnt) begin
                    hit = 1;
                    for (j = 0; j < kw_txt[i].len(); j++)
                        if (kwp[j] != kw_txt[i][j]) hit = 0;
                    if (hit) begin
                        found = 1;
                        k = K_KEYWORD;
                        kw = kw_id[i];
                    end
                end
            end
        end
        emit_tok(k, kw);
    endtask

    task automatic close_sym();
        logic [5:0] k;
        k = lone_kind(psym);
        emit_tok(k, NK);
        if (k == K_INVALID) halt = 1;
    endtask

    task automatic advance(logic [7:0] b, logic [15:0] nl, logic [15:0] nc, output bit took);
        logic [5:0] k;
        took = 0;
        case (md)
            M_IDENT: begin
                if (b == "_" || ch_alpha(b) || ch_digit(b)) begin
                    if (tcnt < 8) kwp[tcnt[2:0]] = b;
                    tcnt = sat16(tcnt);
                    took = 1;
                end else close_word();
            end
            M_NUM_FIRST, M_NUM_INT: begin
                if (md == M_NUM_FIRST && b == "x") md = M_NUM_HEX;
                else if (ch_digit(b)) md = M_NUM_INT;
                else if (b == ".") md = M_NUM_FRAC;
                else begin
                    emit_tok(K_NUMBER, NK);
                    return;
                end
                tcnt = sat16(tcnt);
                took = 1;
            end
            M_NUM_HEX, M_NUM_FRAC: begin
                if ((md == M_NUM_HEX) ? ch_hexd(b) : ch_digit(b)) begin
                    tcnt = sat16(tcnt);
                    took = 1;
                end else emit_tok(K_NUMBER, NK);
            end
            M_STRING: begin
                tcnt = sat16(tcnt);
                took = 1;
                if (esc) begin
                    if (b == "n" || b == "r" || b == CH_QUOTE || b == CH_BSL) begin
                        esc = 0;
                    end else begin
                        emit(K_INVALID, NK, nl, nc, tcnt);
                        md = M_IDLE;
                        halt = 1;
                    end
                end else if (b == CH_BSL) esc = 1;
                else if (b == CH_QUOTE) emit_tok(K_STRING, NK);
            end
            M_LINE_COMMENT: begin
                if (b == CH_NL) emit_tok(K_COMMENT, NK);
                else begin
                    tcnt = sat16(tcnt);
                    took = 1;
                end
            end
            M_BLOCK_COMMENT: begin
                tcnt = sat16(tcnt);
                took = 1;
                if (star && b == "/") emit_tok(K_COMMENT, NK);
                else star = (b == "*");
            end
            M_SYMBOL: begin
                if (psym == "/" && (b == "/" || b == "*")) begin
                    if (b == "/") md = M_LINE_COMMENT;
                    else md = M_BLOCK_COMMENT;
                    star = 0;
                    tcnt = sat16(tcnt);
                    took = 1;
                end else if (psym == "." && ch_digit(b)) begin
                    md = M_NUM_FRAC;
                    tcnt = sat16(tcnt);
                    took = 1;
                end else begin
                    k = duo_kind(psym, b);
                    if (k != K_NONE) begin
                        tcnt = sat16(tcnt);
                        emit_tok(k, NK);
                        took = 1;
                    end else begin
                        close_sym();
                        took = halt;
                    end
                end
            end
            default: took = 0;
        endcase
    endtask

    task automatic open_tok(logic [7:0] b);
        tsl = cl;
        tsc = cc;
        tcnt = 16'd1;
        md = M_IDLE;
        if (ch_blank(b)) return;
        if (b == "_" || ch_alpha(b)) begin
            kwp[0] = b;
            md = M_IDENT;
            return;
        end
        if (ch_digit(b)) begin
            md = M_NUM_FIRST;
            return;
        end
        if (b == CH_QUOTE) begin
            md = M_STRING;
            esc = 0;
            return;
        end
        case (b)
            ",": emit_tok(K_COMMA, NK);
            "?": emit_tok(K_QUESTION, NK);
            ":": emit_tok(K_COLON, NK);
            ";": emit_tok(K_SEMI, NK);
            "{": emit_tok(K_LBRACE, NK);
            "}": emit_tok(K_RBRACE, NK);
            "(": emit_tok(K_LPAREN, NK);
            ")": emit_tok(K_RPAREN, NK);
            "[": emit_tok(K_LBRACKET, NK);
            "]": emit_tok(K_RBRACKET, NK);
            "%": emit_tok(K_MOD, NK);
            "^": emit_tok(K_EXP, NK);
            "+", "-", "*", "/", "@", "<", ">", "!", "=", "|", "&", ".": begin
                psym = b;
                md = M_SYMBOL;
            end
            default: begin
                emit_tok(K_INVALID, NK);
                halt = 1;
            end
        endcase
    endtask

    task automatic flush_pending();
        case (md)
            M_IDENT: close_word();
            M_NUM_FIRST, M_NUM_INT, M_NUM_HEX, M_NUM_FRAC: emit_tok(K_NUMBER, NK);
            M_STRING: begin
                if (esc) begin
                    emit(K_INVALID, NK, cl, cc, tcnt);
                    halt = 1;
                end else emit(K_STRING, NK, tsl, tsc, tcnt);
            end
            M_LINE_COMMENT, M_BLOCK_COMMENT: emit_tok(K_COMMENT, NK);
            M_SYMBOL: close_sym();
            default: ;
        endcase
        md = M_IDLE;
    endtask

    task automatic predict_tokens(t_in_item it);
        logic [7:0]  b;
        logic [15:0] nl, nc;
        bit          took;
        step_res.delete();
        if (halt) return;
        if (it.end_of_input) begin
            flush_pending();
            esc = 0;
            star = 0;
            cl = 16'd1;
            cc = 16'd1;
        end else begin
            b = it.source_byte;
            nl = cl;
            if (b == CH_NL) begin
                nl = sat16(cl);
                nc = 16'd1;
            end else nc = sat16(cc);
            advance(b, nl, nc, took);
            if (!took) open_tok(b);
            cl = nl;
            cc = nc;
        end
        if (step_res.size() > 0) step_res[step_res.size() - 1].last_of_run = 1'b1;
        foreach (step_res[i]) token_q.insert(token_q.size(), step_res[i]);
    endtask

    // sender
    always @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            predict_tokens(i_item);
            if (cur_row.chk) begin
                if (step_res.size() == 0 || step_res[step_res.size() - 1] !== cur_row.v) begin
                    $display("%0t table mismatch: expected %h actual %h", $time, cur_row.v,
                             (step_res.size() == 0) ? '0 : step_res[step_res.size() - 1]);
                    errors++;
                end
            end
        end
        if (!i_valid || !o_stall) begin
            if (src_q.size() > 0 && $urandom_range(0, 99) >= snd_idle) begin
                cur_row = src_q.pop_front();
                i_valid <= 1'b1;
                i_item <= cur_row.it;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (token_q.size() == 0) begin
                $display("%0t unexpected token: expected none actual %h", $time, o_item);
                errors++;
            end else begin
                e = token_q.pop_front();
                if (o_item.token_class !== e.token_class) begin
                    $display("%0t token_class: expected %0d actual %0d", $time,
                             e.token_class, o_item.token_class);
                    errors++;
                end
                if (o_item.keyword_id !== e.keyword_id) begin
                    $display("%0t keyword_id: expected %0d actual %0d", $time,
                             e.keyword_id, o_item.keyword_id);
                    errors++;
                end
                if (o_item.start_line !== e.start_line) begin
                    $display("%0t start_line: expected %0d actual %0d", $time,
                             e.start_line, o_item.start_line);
                    errors++;
                end
                if (o_item.start_column !== e.start_column) begin
                    $display("%0t start_column: expected %0d actual %0d", $time,
                             e.start_column, o_item.start_column);
                    errors++;
                end
                if (o_item.token_length !== e.token_length) begin
                    $display("%0t token_length: expected %0d actual %0d", $time,
                             e.token_length, o_item.token_length);
                    errors++;
                end
                if (o_item.last_of_run !== e.last_of_run) begin
                    $display("%0t last_of_run: expected %0d actual %0d", $time,
                             e.last_of_run, o_item.last_of_run);
                    errors++;
                end
            end
        end
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else if (hold_go) begin
            hold_go = 0;
            hold_left = 300;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < rcv_idle);
        end
    end

    always @(posedge i_clk) begin
        cyc++;
        if (cyc > CYCLE_LIMIT) begin
            $display("script_source_tokenizer_top regression: fail");
            $finish;
        end
    end

    task automatic push_b(logic [7:0] b, bit e = 0);
        t_src_entry s;
        s.it.source_byte = b;
        s.it.end_of_input = e;
        s.chk = 0;
        s.v = '0;
        src_q.insert(src_q.size(), s);
    endtask

    task automatic push_s(string w);
        for (int i = 0; i < w.len(); i++) push_b(w[i]);
    endtask

    function automatic logic [7:0] word_char();
        int r;
        r = $urandom_range(0, 62);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        if (r < 62) return 8'("0" + r - 52);
        return "_";
    endfunction

    function automatic logic [7:0] free_byte(logic [7:0] x1, logic [7:0] x2);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == x1 || b == x2) b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    task automatic gen_token();
        string ops[36] = '{"+", "-", "*", "/", "@", "<", ">", "!", "=", "|", ".", "+=", "-=",
                           "*=", "/=", "@=", "<=", ">=", "!=", "==", "++", "--", "||", "&&",
                           ",", "?", ":", ";", "{", "}", "(", ")", "[", "]", "%", "^"};
        string escs[4] = '{"n", "r", "\"", "\\"};
        logic [7:0] seps[7] = '{8'd32, 8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};
        int r, n, i;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            if ($urandom_range(0, 1)) begin
                n = $urandom_range(0, 17);
                if (n == 17) push_s("SPC");
                else push_s(kw_txt[n]);
            end else begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5);
                push_b(($urandom_range(0, 4) == 0) ? "_" : 8'("a" + $urandom_range(0, 25)));
                for (i = 1; i < n; i++) push_b(word_char());
            end
        end else if (r < 40) begin
            n = $urandom_range(0, 3);
            if (n == 3) push_b(".");
            else push_b(8'("0" + $urandom_range(0, 9)));
            if (n == 1) begin
                push_b("x");
                repeat ($urandom_range(0, 4)) push_b(($urandom_range(0, 1)) ?
                    8'("A" + $urandom_range(0, 5)) : 8'("0" + $urandom_range(0, 9)));
            end else begin
                repeat ($urandom_range(0, 3)) push_b(8'("0" + $urandom_range(0, 9)));
                if (n == 2) push_b(".");
                if (n >= 2) repeat ($urandom_range(1, 3)) push_b(8'("0" + $urandom_range(0, 9)));
            end
        end else if (r < 50) begin
            push_b(CH_QUOTE);
            repeat ($urandom_range(0, 10)) begin
                if ($urandom_range(0, 4) == 0) begin
                    push_b(CH_BSL);
                    push_s(escs[$urandom_range(0, 3)]);
                end else push_b(free_byte(CH_QUOTE, CH_BSL));
            end
            if ($urandom_range(0, 9) == 0) begin
                push_b(8'($urandom_range(0, 255)), 1);
                return;
            end
            push_b(CH_QUOTE);
        end else if (r < 57) begin
            push_s("//");
            repeat ($urandom_range(0, 10)) push_b(free_byte(CH_NL, CH_NL));
            if ($urandom_range(0, 9) == 0) begin
                push_b(8'($urandom_range(0, 255)), 1);
                return;
            end
        end else if (r < 64) begin
            push_s("/*");
            repeat ($urandom_range(0, 10)) push_b(free_byte("/", "/"));
            if ($urandom_range(0, 9) == 0) begin
                push_b(8'($urandom_range(0, 255)), 1);
                return;
            end
            push_s("*/");
        end else if (r < 95) begin
            push_s(ops[$urandom_range(0, 35)]);
        end else begin
            push_b(8'($urandom_range(0, 255)), 1);
            return;
        end
        if ($urandom_range(0, 19) == 0) push_b(8'($urandom_range(0, 255)), 1);
        else push_b(seps[$urandom_range(0, 6)]);
    endtask

    task automatic drain();
        while (src_q.size() > 0 || i_valid) @(posedge i_clk);
        while (token_q.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    t_src_entry dir_tab[] = '{
        '{'{",", 1'b0}, 1'b1, '{K_COMMA, NK, 16'd1, 16'd1, 16'd1, 1'b1}},
        '{'{"i", 1'b0}, 1'b0, '0},
        '{'{"f", 1'b0}, 1'b0, '0},
        '{'{" ", 1'b0}, 1'b1, '{K_KEYWORD, 5'd0, 16'd1, 16'd2, 16'd2, 1'b1}},
        '{'{"S", 1'b0}, 1'b0, '0},
        '{'{"P", 1'b0}, 1'b0, '0},
        '{'{"C", 1'b0}, 1'b0, '0},
        '{'{";", 1'b0}, 1'b1, '{K_SEMI, NK, 16'd1, 16'd8, 16'd1, 1'b1}},
        '{'{"0", 1'b0}, 1'b0, '0},
        '{'{"x", 1'b0}, 1'b0, '0},
        '{'{"F", 1'b0}, 1'b0, '0},
        '{'{"=", 1'b0}, 1'b0, '0},
        '{'{CH_QUOTE, 1'b0}, 1'b0, '0},
        '{'{CH_BSL, 1'b0}, 1'b0, '0},
        '{'{"n", 1'b0}, 1'b0, '0},
        '{'{CH_QUOTE, 1'b0}, 1'b0, '0},
        '{'{CH_NL, 1'b0}, 1'b0, '0},
        '{'{"/", 1'b0}, 1'b0, '0},
        '{'{"/", 1'b0}, 1'b0, '0},
        '{'{8'hFF, 1'b0}, 1'b0, '0},
        '{'{CH_NL, 1'b0}, 1'b0, '0},
        '{'{".", 1'b0}, 1'b0, '0},
        '{'{"5", 1'b0}, 1'b0, '0},
        '{'{" ", 1'b0}, 1'b0, '0},
        '{'{"&", 1'b0}, 1'b0, '0},
        '{'{"&", 1'b0}, 1'b0, '0},
        '{'{"@", 1'b0}, 1'b0, '0},
        '{'{"^", 1'b0}, 1'b0, '0},
        '{'{"<", 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b1}, 1'b1, '{K_LT, NK, 16'd3, 16'd8, 16'd1, 1'b1}}
    };

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_tab[i]) src_q.insert(src_q.size(), dir_tab[i]);
        while (src_q.size() < 420) gen_token();
        drain();
        snd_idle = 81;
        rcv_idle = 11;
        while (src_q.size() < 420) gen_token();
        drain();
        snd_idle = 0;
        rcv_idle = 0;
        while (src_q.size() < 400) gen_token();
        while (src_q.size() > 300) @(posedge i_clk);
        hold_go = 1;
        drain();
        // end on a halting case, then bytes that must be dropped
        push_b(" ");
        case ($urandom_range(0, 2))
            0: begin
                push_b(CH_QUOTE);
                push_b(CH_BSL);
                push_b("q");
            end
            1: begin
                push_b("&");
                push_b("a");
            end
            default: push_b(8'($urandom_range(128, 255)));
        endcase
        repeat (10) push_b(",");
        push_b(8'h00, 1);
        drain();
        repeat (10) @(posedge i_clk);
        if (errors == 0) $display("script_source_tokenizer_top regression: pass");
        else $display("script_source_tokenizer_top regression: fail");
        $finish;
    end

endmodule
